/* rtl/lee_pkg.sv */
`default_nettype none

package lee_pkg;

    localparam int LINE_DEPTH = 64;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
    localparam int CHAR_W     = 8;
    localparam int LEN_W      = 7;
    localparam int CFG_IDX_W  = 2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_ERASE    = 2'd0;
    localparam cfg_idx_t REG_KILL     = 2'd1;
    localparam cfg_idx_t REG_LINE_END = 2'd2;

    localparam logic [CHAR_W-1:0] ERASE_RESET    = 8'd35;
    localparam logic [CHAR_W-1:0] KILL_RESET     = 8'd64;
    localparam logic [CHAR_W-1:0] LINE_END_RESET = 8'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    typedef struct packed {
        logic accept;
        logic start_emit;
        logic issue_rd;
        logic load_char;
        logic load_empty;
    } cmd_t;

    typedef struct packed {
        logic flush_req;
        logic line_empty;
        logic rd_pending;
        logic rd_more;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

/* rtl/lee_ram.sv */
`default_nettype none

module lee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/lee_ctrl.sv */
`default_nettype none

module lee_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire lee_pkg::status_t sts,
    output logic                  in_stall,
    output lee_pkg::cmd_t         cmd
);

    lee_pkg::state_t state_reg;
    lee_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lee_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        cmd        = '0;
        case (state_reg)
            lee_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.flush_req)
                    begin
                        cmd.start_emit = 1'b1;
                        state_next = sts.line_empty ? lee_pkg::ST_EMPTY : lee_pkg::ST_EMIT;
                    end
                end
            end
            lee_pkg::ST_EMIT:
            begin
                // A pending read is moved to the output as soon as the output
                // register frees up, and the next read is issued in the same
                // cycle so the line drains one character per cycle while the output is not stalled.
                cmd.load_char = sts.rd_pending && sts.out_free;
                cmd.issue_rd  = sts.rd_more && (!sts.rd_pending || cmd.load_char);
                if (cmd.load_char && !sts.rd_more)
                begin
                    state_next = lee_pkg::ST_IDLE;
                end
            end
            lee_pkg::ST_EMPTY:
            begin
                if (sts.out_free)
                begin
                    cmd.load_empty = 1'b1;
                    state_next = lee_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lee_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/lee_dp.sv */
`default_nettype none

module lee_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire lee_pkg::cfg_idx_t             cfg_index,
    input  wire logic [lee_pkg::CHAR_W-1:0]    cfg_data,
    input  wire logic [lee_pkg::CHAR_W-1:0]    in_char,
    input  wire logic                          end_of_input,
    input  wire logic                          out_stall,
    input  wire lee_pkg::cmd_t                 cmd,
    output lee_pkg::status_t                   sts,
    output logic                               out_valid,
    output logic      [lee_pkg::CHAR_W-1:0]    out_char,
    output logic                               char_valid,
    output logic      [lee_pkg::LEN_W-1:0]     line_length,
    output logic                               line_overflowed,
    output logic                               last
);

    logic [lee_pkg::CHAR_W-1:0] erase_reg, erase_next;
    logic [lee_pkg::CHAR_W-1:0] kill_reg, kill_next;
    logic [lee_pkg::CHAR_W-1:0] line_end_reg, line_end_next;

    logic [lee_pkg::CNT_W-1:0] fill_reg, fill_next;
    logic                      started_reg, started_next;
    logic                      ovf_reg, ovf_next;

    logic [lee_pkg::CNT_W-1:0] emit_len_reg, emit_len_next;
    logic                      emit_ovf_reg, emit_ovf_next;
    logic [lee_pkg::CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic                      rd_pending_reg, rd_pending_next;

    logic                      out_valid_reg, out_valid_next;
    logic [lee_pkg::CHAR_W-1:0] out_char_reg, out_char_next;
    logic                      char_valid_reg, char_valid_next;
    logic [lee_pkg::CNT_W-1:0] out_len_reg, out_len_next;
    logic                      out_ovf_reg, out_ovf_next;
    logic                      last_reg, last_next;

    logic                      ram_we;
    logic [lee_pkg::CHAR_W-1:0] ram_rdata;
    logic                      store_full;

    lee_ram #(
        .WIDTH (lee_pkg::CHAR_W),
        .DEPTH (lee_pkg::LINE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[lee_pkg::ADDR_W-1:0]),
        .wdata (in_char),
        .re    (cmd.issue_rd),
        .raddr (rd_idx_reg[lee_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign store_full = (fill_reg == lee_pkg::CNT_W'(lee_pkg::LINE_DEPTH));

    assign sts.flush_req  = end_of_input ? started_reg : (in_char == line_end_reg);
    assign sts.line_empty = (fill_reg == '0);
    assign sts.rd_pending = rd_pending_reg;
    assign sts.rd_more    = (rd_idx_reg != emit_len_reg);
    assign sts.out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        erase_next    = erase_reg;
        kill_next     = kill_reg;
        line_end_next = line_end_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                lee_pkg::REG_ERASE:    erase_next    = cfg_data;
                lee_pkg::REG_KILL:     kill_next     = cfg_data;
                lee_pkg::REG_LINE_END: line_end_next = cfg_data;
                default:               ;
            endcase
        end
    end

    // Line editing. Line end wins over erase, and erase over kill.
    always_comb
    begin
        fill_next     = fill_reg;
        started_next  = started_reg;
        ovf_next      = ovf_reg;
        emit_len_next = emit_len_reg;
        emit_ovf_next = emit_ovf_reg;
        ram_we        = 1'b0;
        if (cmd.start_emit)
        begin
            emit_len_next = fill_reg;
            emit_ovf_next = ovf_reg;
            fill_next     = '0;
            started_next  = 1'b0;
            ovf_next      = 1'b0;
        end
        else if (cmd.accept && !end_of_input)
        begin
            started_next = 1'b1;
            if (in_char == erase_reg)
            begin
                if (fill_reg != '0)
                begin
                    fill_next = fill_reg - lee_pkg::CNT_W'(1);
                end
            end
            else if (in_char == kill_reg)
            begin
                fill_next = '0;
                ovf_next  = 1'b0;
            end
            else if (!store_full)
            begin
                ram_we    = 1'b1;
                fill_next = fill_reg + lee_pkg::CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        rd_idx_next     = rd_idx_reg;
        rd_pending_next = rd_pending_reg;
        if (cmd.start_emit)
        begin
            rd_idx_next     = '0;
            rd_pending_next = 1'b0;
        end
        else
        begin
            if (cmd.issue_rd)
            begin
                rd_idx_next = rd_idx_reg + lee_pkg::CNT_W'(1);
            end
            rd_pending_next = cmd.issue_rd || (rd_pending_reg && !cmd.load_char);
        end
    end

    // The output register holds one word until it is taken.
    always_comb
    begin
        out_valid_next  = out_valid_reg && out_stall;
        out_char_next   = out_char_reg;
        char_valid_next = char_valid_reg;
        out_len_next    = out_len_reg;
        out_ovf_next    = out_ovf_reg;
        last_next       = last_reg;
        if (cmd.load_char)
        begin
            out_valid_next  = 1'b1;
            out_char_next   = ram_rdata;
            char_valid_next = 1'b1;
            out_len_next    = emit_len_reg;
            out_ovf_next    = emit_ovf_reg;
            last_next       = !sts.rd_more;
        end
        else if (cmd.load_empty)
        begin
            out_valid_next  = 1'b1;
            out_char_next   = '0;
            char_valid_next = 1'b0;
            out_len_next    = '0;
            out_ovf_next    = emit_ovf_reg;
            last_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            erase_reg      <= lee_pkg::ERASE_RESET;
            kill_reg       <= lee_pkg::KILL_RESET;
            line_end_reg   <= lee_pkg::LINE_END_RESET;
            fill_reg       <= '0;
            started_reg    <= 1'b0;
            ovf_reg        <= 1'b0;
            rd_idx_reg     <= '0;
            rd_pending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            erase_reg      <= erase_next;
            kill_reg       <= kill_next;
            line_end_reg   <= line_end_next;
            fill_reg       <= fill_next;
            started_reg    <= started_next;
            ovf_reg        <= ovf_next;
            rd_idx_reg     <= rd_idx_next;
            rd_pending_reg <= rd_pending_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        emit_len_reg   <= emit_len_next;
        emit_ovf_reg   <= emit_ovf_next;
        out_char_reg   <= out_char_next;
        char_valid_reg <= char_valid_next;
        out_len_reg    <= out_len_next;
        out_ovf_reg    <= out_ovf_next;
        last_reg       <= last_next;
    end

    assign out_valid       = out_valid_reg;
    assign out_char        = out_char_reg;
    assign char_valid      = char_valid_reg;
    assign line_length     = lee_pkg::LEN_W'(out_len_reg);
    assign line_overflowed = out_ovf_reg;
    assign last            = last_reg;

endmodule

`default_nettype wire

/* rtl/line_editor_erase_kill.sv */
// Channel   Handshake             Word
// input     in_valid / in_stall   in_char, end_of_input
// output    out_valid / out_stall out_char, char_valid, line_length, line_overflowed, last
// config    cfg_we                cfg_index, cfg_data
//
// An ordinary, erase or kill character, or an end of input that flushes nothing,
// is taken without stalling the input. A line flush streams one character per cycle,
// while the output is not stalled, from the registered-read line store, and holds the
// input until its last character is loaded; an empty line gives one word with char_valid low.
// A stall on the output pauses the drain without losing or repeating a word.
// Reset loads the default erase, kill and line-end codes and empties the line.
`default_nettype none

module line_editor_erase_kill (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire lee_pkg::cfg_idx_t             cfg_index,
    input  wire logic [lee_pkg::CHAR_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [lee_pkg::CHAR_W-1:0]    in_char,
    input  wire logic                          end_of_input,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [lee_pkg::CHAR_W-1:0]    out_char,
    output logic                               char_valid,
    output logic      [lee_pkg::LEN_W-1:0]     line_length,
    output logic                               line_overflowed,
    output logic                               last
);

    lee_pkg::cmd_t    cmd;
    lee_pkg::status_t sts;

    lee_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    lee_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_char         (in_char),
        .end_of_input    (end_of_input),
        .out_stall       (out_stall),
        .cmd             (cmd),
        .sts             (sts),
        .out_valid       (out_valid),
        .out_char        (out_char),
        .char_valid      (char_valid),
        .line_length     (line_length),
        .line_overflowed (line_overflowed),
        .last            (last)
    );

endmodule

`default_nettype wire

/* verif/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = lee_pkg::LINE_DEPTH + 8;
    localparam int HOLD_CYCLES  = 300;

    typedef struct {
        logic [lee_pkg::CHAR_W-1:0] ch;
        logic                       eoi;
    } key_word_t;

    typedef struct {
        logic [lee_pkg::CHAR_W-1:0] ch;
        logic                       is_char;
        logic [lee_pkg::LEN_W-1:0]  len;
        logic                       ovf;
        logic                       is_last;
    } line_out_t;

    typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    lee_pkg::cfg_idx_t          cfg_index = lee_pkg::REG_ERASE;
    logic [lee_pkg::CHAR_W-1:0] cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [lee_pkg::CHAR_W-1:0] in_char = '0;
    logic                       end_of_input = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [lee_pkg::CHAR_W-1:0] out_char;
    logic                       char_valid;
    logic [lee_pkg::LEN_W-1:0]  line_length;
    logic                       line_overflowed;
    logic                       last;

    line_editor_erase_kill u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_char         (in_char),
        .end_of_input    (end_of_input),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_char        (out_char),
        .char_valid      (char_valid),
        .line_length     (line_length),
        .line_overflowed (line_overflowed),
        .last            (last)
    );

    always #6 clk = ~clk;

    // Pending keystrokes and the characters the editor should emit for them.
    key_word_t key_q[$];
    line_out_t line_expect_q[$];

    // Shadow copy of the editor state and its control codes.
    logic [lee_pkg::CHAR_W-1:0] line_buf[lee_pkg::LINE_DEPTH];
    int                         held;
    bit                         started;
    bit                         dropped;
    logic [lee_pkg::CHAR_W-1:0] erase_code;
    logic [lee_pkg::CHAR_W-1:0] kill_code;
    logic [lee_pkg::CHAR_W-1:0] eol_code;

    bit       failed;
    bit       in_took;
    int       results_seen;
    int       words_queued;
    int       burst_left;
    int       gap_left;
    int       hold_left;
    bit       hold_done;
    int       stall_span;
    rx_mode_t stall_mode = RX_FREE;

    function automatic void flush_line();
        line_out_t r;
        if (held == 0)
        begin
            r.ch = '0;
            r.is_char = 1'b0;
            r.len = '0;
            r.ovf = dropped;
            r.is_last = 1'b1;
            line_expect_q.push_back(r);
        end
        else
        begin
            for (int k = 0; k < held; k++)
            begin
                r.ch = line_buf[k];
                r.is_char = 1'b1;
                r.len = lee_pkg::LEN_W'(held);
                r.ovf = dropped;
                r.is_last = (k == held - 1);
                line_expect_q.push_back(r);
            end
        end
        held = 0;
        started = 1'b0;
        dropped = 1'b0;
    endfunction

    function automatic void predict_keystroke(input logic [lee_pkg::CHAR_W-1:0] ch,
                                              input logic eoi);
        if (eoi)
        begin
            if (started)
                flush_line();
        end
        else
        begin
            started = 1'b1;
            // Line end wins over erase, and erase over kill, when codes collide.
            if (ch == eol_code)
                flush_line();
            else if (ch == erase_code)
            begin
                if (held > 0)
                    held--;
            end
            else if (ch == kill_code)
            begin
                held = 0;
                dropped = 1'b0;
            end
            else if (held < lee_pkg::LINE_DEPTH)
            begin
                line_buf[held] = ch;
                held++;
            end
            else
                dropped = 1'b1;
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            failed = 1'b1;
        end
    endfunction

    always @(posedge clk)
    begin
        line_out_t want;
        in_took = rst_n && in_valid && !in_stall;
        if (in_took)
            predict_keystroke(in_char, end_of_input);
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (line_expect_q.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual char %0h last %0b",
                         $time, out_char, last);
                failed = 1'b1;
            end
            else
            begin
                want = line_expect_q.pop_front();
                check_field("out_char", want.ch, out_char);
                check_field("char_valid", 8'(want.is_char), 8'(char_valid));
                check_field("line_length", 8'(want.len), 8'(line_length));
                check_field("line_overflowed", 8'(want.ovf), 8'(line_overflowed));
                check_field("last", 8'(want.is_last), 8'(last));
            end
        end
    end

    // Sender: bursts of random length separated by random gaps, which may be empty.
    always @(negedge clk)
    begin
        key_word_t w;
        if (rst_n && (!in_valid || in_took))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (key_q.size() != 0)
            begin
                w = key_q.pop_front();
                in_valid <= 1'b1;
                in_char <= w.ch;
                end_of_input <= w.eoi;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: a changing stall pattern, plus one long hold-off that lets the
    // editor back up and stall its input.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && results_seen >= 12)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (stall_span == 0)
                begin
                    stall_mode = rx_mode_t'($urandom_range(0, 3));
                    stall_span = $urandom_range(8, 48);
                end
                stall_span--;
                case (stall_mode)
                    RX_FREE:     out_stall <= 1'b0;
                    RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY:    out_stall <= ($urandom_range(0, 2) != 0);
                    RX_PERIODIC: out_stall <= (stall_span % 3 == 0);
                    default:     out_stall <= 1'b0;
                endcase
            end
        end
    end

    function automatic void queue_word(input logic [lee_pkg::CHAR_W-1:0] ch, input logic eoi);
        key_word_t w;
        w.ch = ch;
        w.eoi = eoi;
        key_q.push_back(w);
        words_queued++;
    endfunction

    function automatic logic [lee_pkg::CHAR_W-1:0] plain_char();
        logic [lee_pkg::CHAR_W-1:0] c;
        c = lee_pkg::CHAR_W'($urandom_range(0, 255));
        while (c == erase_code || c == kill_code || c == eol_code)
            c = lee_pkg::CHAR_W'($urandom_range(0, 255));
        return c;
    endfunction

    // Fill the store past capacity, erase past empty, then end the line:
    // the dropped-character flag has to survive the erases.
    function automatic void queue_overflow_erase();
        repeat (lee_pkg::LINE_DEPTH + 2) queue_word(plain_char(), 1'b0);
        repeat (lee_pkg::LINE_DEPTH + 3) queue_word(erase_code, 1'b0);
        queue_word(eol_code, 1'b0);
    endfunction

    function automatic void queue_text(input int budget);
        int first;
        int n;
        int r;
        first = words_queued;
        while (words_queued - first < budget)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                n = lee_pkg::LINE_DEPTH + $urandom_range(0, 6);
                repeat (n) queue_word(plain_char(), 1'b0);
                repeat ($urandom_range(0, 3)) queue_word(erase_code, 1'b0);
                if ($urandom_range(0, 3) == 0)
                    queue_word(kill_code, 1'b0);
            end
            else
            begin
                n = $urandom_range(0, 10);
                repeat (n)
                begin
                    r = $urandom_range(0, 31);
                    if (r < 3)
                        queue_word(erase_code, 1'b0);
                    else if (r == 3)
                        queue_word(kill_code, 1'b0);
                    else
                        queue_word(lee_pkg::CHAR_W'($urandom_range(0, 255)), 1'b0);
                end
            end
            r = $urandom_range(0, 19);
            if (r < 14)
                queue_word(eol_code, 1'b0);
            else if (r < 16)
            begin
                // The trailing end of input finds an unstarted line.
                queue_word(eol_code, 1'b0);
                queue_word(lee_pkg::CHAR_W'($urandom_range(0, 255)), 1'b1);
            end
            else if (r < 19)
                queue_word(lee_pkg::CHAR_W'($urandom_range(0, 255)), 1'b1);
        end
    endfunction

    task automatic wait_idle();
        while (key_q.size() != 0 || in_valid || line_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_codes(input logic [lee_pkg::CHAR_W-1:0] e,
                             input logic [lee_pkg::CHAR_W-1:0] k,
                             input logic [lee_pkg::CHAR_W-1:0] l);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= lee_pkg::REG_ERASE;
        cfg_data <= e;
        @(negedge clk);
        cfg_index <= lee_pkg::REG_KILL;
        cfg_data <= k;
        @(negedge clk);
        cfg_index <= lee_pkg::REG_LINE_END;
        cfg_data <= l;
        @(negedge clk);
        cfg_we <= 1'b0;
        erase_code = e;
        kill_code = k;
        eol_code = l;
    endtask

    initial
    begin
        logic [lee_pkg::CHAR_W-1:0] c;
        held = 0;
        started = 1'b0;
        dropped = 1'b0;
        erase_code = lee_pkg::ERASE_RESET;
        kill_code = lee_pkg::KILL_RESET;
        eol_code = lee_pkg::LINE_END_RESET;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part with the reset codes.
        queue_word(lee_pkg::LINE_END_RESET, 1'b0);
        queue_word(8'h00, 1'b1);
        queue_word(8'h41, 1'b0);
        queue_word(8'h00, 1'b0);
        queue_word(8'hFF, 1'b0);
        queue_word(lee_pkg::LINE_END_RESET, 1'b0);
        queue_word(8'h42, 1'b0);
        repeat (3) queue_word(lee_pkg::ERASE_RESET, 1'b0);
        queue_word(lee_pkg::LINE_END_RESET, 1'b0);
        queue_word(8'h43, 1'b0);
        queue_word(8'h44, 1'b0);
        queue_word(lee_pkg::KILL_RESET, 1'b0);
        queue_word(8'h45, 1'b0);
        queue_word(lee_pkg::LINE_END_RESET, 1'b1);
        queue_word(8'hFF, 1'b1);
        queue_word(lee_pkg::KILL_RESET, 1'b0);
        queue_word(8'h00, 1'b1);
        wait_idle();

        queue_overflow_erase();
        queue_text(20);
        wait_idle();

        set_codes(8'h00, 8'hFF, 8'h80);
        queue_text(6);
        wait_idle();

        // Erase and kill share a code, so the code always acts as erase.
        set_codes(8'h55, 8'h55, 8'hAA);
        queue_text(6);
        wait_idle();

        // Kill and line end share a code, so the code always ends the line.
        c = lee_pkg::CHAR_W'($urandom_range(0, 255));
        set_codes(lee_pkg::CHAR_W'($urandom_range(0, 255)), c, c);
        queue_text(6);
        wait_idle();

        set_codes(lee_pkg::CHAR_W'($urandom_range(0, 255)),
                  lee_pkg::CHAR_W'($urandom_range(0, 255)),
                  lee_pkg::CHAR_W'($urandom_range(0, 255)));
        queue_text(6);
        wait_idle();

        set_codes(lee_pkg::ERASE_RESET, lee_pkg::KILL_RESET, lee_pkg::LINE_END_RESET);
        queue_text(6);
        wait_idle();

        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
